@@ hdl/bezier_de_casteljau_eval_unit_assert.svh @@
// Assertion macros for the de Casteljau evaluator.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef BEZIER_DE_CASTELJAU_EVAL_UNIT_ASSERT_SVH
`define BEZIER_DE_CASTELJAU_EVAL_UNIT_ASSERT_SVH

// checked only out of reset
`define BDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/bdc_pkg.sv @@
// Shared types and constants of the de Casteljau evaluator.
// No dependencies.
package bdc_pkg;

  localparam int COORD_W = 24;
  localparam int T_FRAC  = 16;
  localparam int T_W     = T_FRAC + 1;
  localparam int IDX_W   = 4;
  localparam int PC_W    = 5;

  localparam logic [PC_W-1:0] PC_RESET = PC_W'(4);
  localparam logic [T_W-1:0]  T_ONE    = T_W'(1) << T_FRAC;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef struct packed {
    op_e                       operation;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [T_W-1:0]            t_param;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
  } out_item_t;

  // control from the sequencer to every cell of the row
  typedef struct packed {
    logic             store_we;
    logic [IDX_W-1:0] store_idx;
    logic             row_load;
    logic             row_step;
  } row_ctrl_t;

endpackage

@@ hdl/bdc_lerp_cell.sv @@
// One cell of the reduction row: holds one control point and one working point.
// Depends on bdc_pkg.
module bdc_lerp_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                               clk_i,
  input  bdc_pkg::row_ctrl_t                 ctrl_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] wr_x_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] wr_y_i,
  input  logic [bdc_pkg::T_W-1:0]            t_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] nb_x_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] nb_y_i,
  output logic signed [bdc_pkg::COORD_W-1:0] q_x_o,
  output logic signed [bdc_pkg::COORD_W-1:0] q_y_o
);

  localparam int CW     = bdc_pkg::COORD_W;
  localparam int PROD_W = CW + 1 + bdc_pkg::T_W + 1;

  logic signed [CW-1:0] px_q, py_q;
  logic signed [CW-1:0] qx_q, qy_q;
  logic signed [CW-1:0] qx_d, qy_d;
  logic                 hit;

  // a + floor((b - a) * t / 2^T_FRAC + 1/2)
  function automatic logic signed [CW-1:0] lerp(
    input logic signed [CW-1:0]      a,
    input logic signed [CW-1:0]      b,
    input logic [bdc_pkg::T_W-1:0]   t
  );
    logic signed [CW:0]       d;
    logic signed [PROD_W-1:0] p;
    logic signed [PROD_W-1:0] s;
    d = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    p = d * $signed({1'b0, t});
    p = p + (PROD_W'(1) <<< (bdc_pkg::T_FRAC - 1));
    s = p >>> bdc_pkg::T_FRAC;
    return a + s[CW-1:0];
  endfunction

  assign hit = ctrl_i.store_we && (32'(ctrl_i.store_idx) == CELL_INDEX);

  always_ff @(posedge clk_i) begin
    if (hit) begin
      px_q <= wr_x_i;
      py_q <= wr_y_i;
    end
  end

  always_comb begin
    qx_d = qx_q;
    qy_d = qy_q;
    if (ctrl_i.row_load) begin
      qx_d = px_q;
      qy_d = py_q;
    end else if (ctrl_i.row_step) begin
      qx_d = lerp(qx_q, nb_x_i, t_i);
      qy_d = lerp(qy_q, nb_y_i, t_i);
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    qy_q <= qy_d;
  end

  assign q_x_o = qx_q;
  assign q_y_o = qy_q;

endmodule

@@ hdl/bdc_ctrl.sv @@
// Sequencer: handshakes, point_count register, level counter and result register.
// Depends on bdc_pkg and bezier_de_casteljau_eval_unit_assert.svh.
`include "bezier_de_casteljau_eval_unit_assert.svh"

module bdc_ctrl #(
  parameter int MAX_POINTS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bdc_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bdc_pkg::out_item_t                 out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bdc_pkg::PC_W-1:0]           cfg_data_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] q0_x_i,
  input  logic signed [bdc_pkg::COORD_W-1:0] q0_y_i,
  output bdc_pkg::row_ctrl_t                 row_ctrl_o,
  output logic [bdc_pkg::T_W-1:0]            t_o
);

  localparam int LVL_W = $clog2(MAX_POINTS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [bdc_pkg::PC_W-1:0] pc_q;
  logic [LVL_W-1:0]         lvl_q, lvl_d;
  logic [bdc_pkg::T_W-1:0]  t_q, t_d;
  logic                     out_valid_q, out_valid_d;
  bdc_pkg::out_item_t       out_q;
  logic                     in_acc, acc_eval, acc_load, step, emit;
  int unsigned              levels;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign acc_eval    = in_acc && (in_data_i.operation == bdc_pkg::OP_EVAL);
  assign acc_load    = in_acc && (in_data_i.operation == bdc_pkg::OP_LOAD);
  assign step        = (state_q == ST_RUN) && (lvl_q != '0);
  assign emit        = (state_q == ST_RUN) && (lvl_q == '0) && (!out_valid_q || !out_stall_i);

  // reduction levels = clamp(point_count, 1, MAX_POINTS) - 1
  always_comb begin
    if (pc_q <= bdc_pkg::PC_W'(1)) begin
      levels = 0;
    end else if (32'(pc_q) > MAX_POINTS) begin
      levels = MAX_POINTS - 1;
    end else begin
      levels = 32'(pc_q) - 1;
    end
  end

  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    t_d     = t_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_eval) begin
          state_d = ST_RUN;
          lvl_d   = LVL_W'(levels);
          t_d     = (in_data_i.t_param > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE
                                                         : in_data_i.t_param;
        end
      end
      ST_RUN: begin
        if (step) begin
          lvl_d = lvl_q - LVL_W'(1);
        end else if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= bdc_pkg::PC_RESET;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    if (emit) begin
      out_q.curve_x <= q0_x_i;
      out_q.curve_y <= q0_y_i;
    end
  end

  assign row_ctrl_o.store_we  = acc_load;
  assign row_ctrl_o.store_idx = in_data_i.point_index;
  assign row_ctrl_o.row_load  = acc_eval;
  assign row_ctrl_o.row_step  = step;
  assign t_o                  = t_q;
  assign out_valid_o          = out_valid_q;
  assign out_data_o           = out_q;

  `BDC_ASSERT(a_eval_starts_run, acc_eval |=> (state_q == ST_RUN), "evaluate item did not start a run")
  `BDC_ASSERT(a_level_counts_down, step |=> (lvl_q == $past(lvl_q) - LVL_W'(1)), "level counter skipped")
  `BDC_ASSERT(a_t_clamped, (state_q == ST_RUN) |-> (t_q <= bdc_pkg::T_ONE), "t above one in use")
  `BDC_ASSERT_ALWAYS(a_load_no_result, (rst_ni && acc_load && !out_valid_q) |=> !out_valid_q, "load item gave a result")

endmodule

@@ hdl/bezier_de_casteljau_eval_unit.sv @@
// Top level of the de Casteljau Bezier evaluator: sequencer and a row of lerp cells.
// Depends on bdc_pkg, bdc_ctrl and bdc_lerp_cell.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------
//   in      | input     | in_valid_i/stall_o | bdc_pkg::in_item_t
//   out     | output    | out_valid_o/stall_i| bdc_pkg::out_item_t
//   cfg     | input     | cfg_valid_i/ready_o| point_count, 5 bits
//
// A load item writes one point of the store. An evaluate item with n points in use
// copies the stored points into the cell row as it is taken, runs n - 1 reduction levels
// (one per cycle through the row of lerp cells), then captures the result once free.
// Reset clears control and sets point_count to 4; the point store is not cleared.
// A stalled result is held in the output register; the next item is taken meanwhile.
module bezier_de_casteljau_eval_unit #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bdc_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bdc_pkg::out_item_t       out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bdc_pkg::PC_W-1:0] cfg_data_i
);

  bdc_pkg::row_ctrl_t              row_ctrl;
  logic [bdc_pkg::T_W-1:0]         t_cur;
  logic signed [bdc_pkg::COORD_W-1:0] q_x [MAX_POINTS];
  logic signed [bdc_pkg::COORD_W-1:0] q_y [MAX_POINTS];

  bdc_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q0_x_i      (q_x[0]),
    .q0_y_i      (q_y[0]),
    .row_ctrl_o  (row_ctrl),
    .t_o         (t_cur)
  );

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    logic signed [bdc_pkg::COORD_W-1:0] nb_x, nb_y;
    // the last cell has no right neighbour; it interpolates against itself
    if (k == MAX_POINTS - 1) begin : g_end
      assign nb_x = q_x[k];
      assign nb_y = q_y[k];
    end else begin : g_mid
      assign nb_x = q_x[k+1];
      assign nb_y = q_y[k+1];
    end

    bdc_lerp_cell #(
      .CELL_INDEX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (row_ctrl),
      .wr_x_i (in_data_i.x_coord),
      .wr_y_i (in_data_i.y_coord),
      .t_i    (t_cur),
      .nb_x_i (nb_x),
      .nb_y_i (nb_y),
      .q_x_o  (q_x[k]),
      .q_y_o  (q_y[k])
    );
  end

endmodule

@@ tb/bezier_de_casteljau_eval_unit_test.sv @@
// Self-checking testbench of the de Casteljau Bezier evaluator.
// Depends on bdc_pkg and bezier_de_casteljau_eval_unit; holds its own curve predictor.
`timescale 1ns / 1ps

module bezier_de_casteljau_eval_unit_test;

  localparam int NUM_POINTS = 16;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam longint T_UNIT = 64'sd1 << bdc_pkg::T_FRAC;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  bdc_pkg::in_item_t        in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  bdc_pkg::out_item_t       out_data_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [bdc_pkg::PC_W-1:0] cfg_data_i = '0;

  // predictor state
  logic signed [bdc_pkg::COORD_W-1:0] ctrl_x[NUM_POINTS];
  logic signed [bdc_pkg::COORD_W-1:0] ctrl_y[NUM_POINTS];
  logic [bdc_pkg::PC_W-1:0]           point_count_q = bdc_pkg::PC_RESET;
  bdc_pkg::out_item_t                 curve_expected[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int seg_no = 0;
  int n_errors = 0;
  int n_loads = 0;
  int n_evals = 0;
  int n_points_out = 0;
  int n_cfg = 0;

  bezier_de_casteljau_eval_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // one lerp step, round half up; >>> on a signed longint floors
  function automatic longint lerp_round(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t + (T_UNIT / 2);
    return a + (p >>> bdc_pkg::T_FRAC);
  endfunction

  function automatic bdc_pkg::out_item_t casteljau_point(logic [bdc_pkg::T_W-1:0] t_raw);
    longint             qx[NUM_POINTS];
    longint             qy[NUM_POINTS];
    longint             t;
    int                 n;
    bdc_pkg::out_item_t res;
    n = int'(point_count_q);
    if (n < 1) n = 1;
    if (n > NUM_POINTS) n = NUM_POINTS;
    t = longint'(t_raw);
    if (t > T_UNIT) t = T_UNIT;
    for (int i = 0; i < n; i++) begin
      qx[i] = longint'(ctrl_x[i]);
      qy[i] = longint'(ctrl_y[i]);
    end
    for (int lvl = 0; lvl < n - 1; lvl++) begin
      for (int j = 0; j < n - lvl - 1; j++) begin
        qx[j] = lerp_round(qx[j], qx[j+1], t);
        qy[j] = lerp_round(qy[j], qy[j+1], t);
      end
    end
    res.curve_x = qx[0][bdc_pkg::COORD_W-1:0];
    res.curve_y = qy[0][bdc_pkg::COORD_W-1:0];
    return res;
  endfunction

  function automatic logic [bdc_pkg::COORD_W-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return {1'b0, {(bdc_pkg::COORD_W-1){1'b1}}};
    if (sel == 1) return {1'b1, {(bdc_pkg::COORD_W-1){1'b0}}};
    return bdc_pkg::COORD_W'($urandom);
  endfunction

  function automatic logic [bdc_pkg::T_W-1:0] rand_t();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return bdc_pkg::T_ONE;
    if (sel <= 3) return bdc_pkg::T_W'($urandom);  // may exceed one
    return bdc_pkg::T_W'($urandom_range(0, int'(bdc_pkg::T_ONE)));
  endfunction

  function automatic bdc_pkg::in_item_t make_load(int idx, logic [bdc_pkg::COORD_W-1:0] x,
                                                  logic [bdc_pkg::COORD_W-1:0] y);
    bdc_pkg::in_item_t it;
    it.operation   = bdc_pkg::OP_LOAD;
    it.point_index = bdc_pkg::IDX_W'(idx);
    it.x_coord     = x;
    it.y_coord     = y;
    it.t_param     = bdc_pkg::T_W'($urandom);
    return it;
  endfunction

  function automatic bdc_pkg::in_item_t make_eval(logic [bdc_pkg::T_W-1:0] t);
    bdc_pkg::in_item_t it;
    it.operation   = bdc_pkg::OP_EVAL;
    it.point_index = bdc_pkg::IDX_W'($urandom);
    it.x_coord     = bdc_pkg::COORD_W'($urandom);
    it.y_coord     = bdc_pkg::COORD_W'($urandom);
    it.t_param     = t;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, valid still high
  task automatic send_item(bdc_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!(in_valid_i && !in_stall_o)) @(posedge clk_i);
    if (it.operation == bdc_pkg::OP_LOAD) begin
      ctrl_x[it.point_index] = it.x_coord;
      ctrl_y[it.point_index] = it.y_coord;
      n_loads++;
    end else begin
      curve_expected.push_back(casteljau_point(it.t_param));
      n_evals++;
    end
    @(negedge clk_i);
  endtask

  // only once the block has drained
  task automatic write_point_count(logic [bdc_pkg::PC_W-1:0] value);
    in_valid_i <= 1'b0;
    while (curve_expected.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    point_count_q = value;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // every entry is written first, so no evaluate reads an unwritten point
  task automatic test_load_extremes();
    for (int i = 0; i < NUM_POINTS; i++) begin
      case (i)
        0: begin
          send_item(make_load(i, {1'b0, {(bdc_pkg::COORD_W-1){1'b1}}},
                              {1'b1, {(bdc_pkg::COORD_W-1){1'b0}}}));
        end
        1: begin
          send_item(make_load(i, {1'b1, {(bdc_pkg::COORD_W-1){1'b0}}},
                              {1'b0, {(bdc_pkg::COORD_W-1){1'b1}}}));
        end
        2: begin
          send_item(make_load(i, {1'b0, {(bdc_pkg::COORD_W-1){1'b1}}}, '1));
        end
        3: begin
          send_item(make_load(i, '0, {1'b0, {(bdc_pkg::COORD_W-1){1'b1}}}));
        end
        default: begin
          send_item(make_load(i, rand_coord(), rand_coord()));
        end
      endcase
    end
  endtask

  task automatic test_eval_t_extremes();
    send_item(make_eval('0));
    send_item(make_eval(bdc_pkg::T_ONE));
    send_item(make_eval('1));          // above one, clamped
    send_item(make_eval(bdc_pkg::T_W'(1)));
    send_item(make_eval(bdc_pkg::T_ONE >> 1));
    send_item(make_eval(bdc_pkg::T_ONE - 1));
  endtask

  task automatic test_count_limits();
    write_point_count('0);             // zero behaves as one point
    send_item(make_eval(bdc_pkg::T_W'(40000)));
    write_point_count('1);             // above the store size, clamped
    send_item(make_eval(rand_t()));
    write_point_count(bdc_pkg::PC_W'(NUM_POINTS));
    send_item(make_eval(bdc_pkg::T_ONE));
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
    logic [bdc_pkg::PC_W-1:0] extremes[6];
    int                       sent;
    int                       seg_len;
    extremes = '{bdc_pkg::PC_W'(1), bdc_pkg::PC_W'(16), bdc_pkg::PC_W'(0),
                 bdc_pkg::PC_W'(31), bdc_pkg::PC_W'(17), bdc_pkg::PC_W'(2)};
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if (seg_no < 6) write_point_count(extremes[seg_no]);
      else if ($urandom_range(0, 7) == 0) write_point_count(bdc_pkg::PC_W'($urandom));
      else write_point_count(bdc_pkg::PC_W'($urandom_range(1, 8)));
      seg_no++;
      seg_len = $urandom_range(15, 30);
      for (int k = 0; k < seg_len; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          send_item(make_load($urandom_range(0, NUM_POINTS - 1), rand_coord(), rand_coord()));
        end else begin
          send_item(make_eval(rand_t()));
        end
      end
      sent += seg_len;
    end
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    write_point_count(bdc_pkg::PC_W'(3));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    for (int k = 0; k < 40; k++) begin
      if (k % 3 == 0) begin
        send_item(make_load($urandom_range(0, NUM_POINTS - 1), rand_coord(), rand_coord()));
      end else begin
        send_item(make_eval(rand_t()));
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bdc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_points_out++;
      if (curve_expected.size() == 0) begin
        $display("%0t ERROR unexpected item x=%0d y=%0d", $time,
                 out_data_o.curve_x, out_data_o.curve_y);
        n_errors++;
      end else begin
        want = curve_expected.pop_front();
        if (out_data_o.curve_x !== want.curve_x) begin
          $display("%0t ERROR curve_x expected %0d actual %0d", $time,
                   want.curve_x, out_data_o.curve_x);
          n_errors++;
        end
        if (out_data_o.curve_y !== want.curve_y) begin
          $display("%0t ERROR curve_y expected %0d actual %0d", $time,
                   want.curve_y, out_data_o.curve_y);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ERROR no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_load_extremes();
    test_eval_t_extremes();
    test_count_limits();
    test_random_phase(23, 74, 140);
    test_random_phase(74, 23, 140);
    test_random_phase(0, 0, 140);
    test_backpressure();

    in_valid_i <= 1'b0;
    while (curve_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (curve_expected.size() != 0) begin
      $display("%0t ERROR %0d curve points never arrived", $time, curve_expected.size());
      n_errors++;
    end

    $display("Covered %0d point loads and %0d evaluations over %0d point_count writes,",
             n_loads, n_evals, n_cfg);
    $display("with %0d curve points checked under three idle mixes and a long hold-off.",
             n_points_out);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
